// File: src/stpc_pkg.sv
// shared types and constants for the two-point sensor calibration block
package stpc_pkg;

    // default number of fraction bits of the result
    localparam int FRAC_BITS_DEF = 8;

    // fixed field widths
    localparam int RAW_W     = 16;
    localparam int VAL_W     = 32;
    localparam int HUM_PCT_W = 7;
    localparam int TEMP_X8_W = 10;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // saturation bounds of the result
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // request opcodes
    localparam logic OP_HUM  = 1'b0;
    localparam logic OP_TEMP = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HUM_LOW_PCT   = 3'd0,
        REG_HUM_HIGH_PCT  = 3'd1,
        REG_HUM_LOW_RAW   = 3'd2,
        REG_HUM_HIGH_RAW  = 3'd3,
        REG_TEMP_LOW_X8   = 3'd4,
        REG_TEMP_HIGH_X8  = 3'd5,
        REG_TEMP_LOW_RAW  = 3'd6,
        REG_TEMP_HIGH_RAW = 3'd7
    } reg_idx_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } stpc_div_stat_t;

endpackage

// File: src/sensor_two_point_calibration.sv
// two-point linear calibration of raw humidity and temperature samples
// a request runs through setup, multiply, divider load, the bit-serial divider,
//   saturating sum and output states
// stale temperature and equal calibration points go from setup straight to output
// throughput: one request at a time; s_ready is high only while the sequencer is idle
// reset: synchronous active-low aresetn clears the sequencer, the result valid flag,
//   the last temperature and loads the calibration register defaults
module sensor_two_point_calibration #(
    parameter int FRAC_BITS = stpc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic signed [stpc_pkg::RAW_W-1:0] s_raw_sample,
    input  logic                            s_sample_ready,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [stpc_pkg::VAL_W-1:0] m_value,
    output logic                            m_stale,
    output logic                            m_div_error,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stpc_pkg::ADDR_W-1:0]     paddr,
    input  logic [stpc_pkg::DATA_W-1:0]     pwdata,
    output logic [stpc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int RW   = stpc_pkg::RAW_W;
    localparam int VW   = stpc_pkg::VAL_W;
    localparam int YW   = stpc_pkg::HUM_PCT_W + FRAC_BITS;  // scaled calibration value
    localparam int DYW  = YW + 1;                           // signed value span
    localparam int DXW  = RW + 1;                           // signed raw span
    localparam int NUMW = DYW + DXW;                        // signed product
    localparam int NW   = NUMW - 1;                         // product magnitude
    localparam int SUMW = NW + 2;
    localparam int EXTW = (SUMW > VW + 1) ? SUMW : VW + 1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DLOAD = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_SUM   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // configuration registers
    logic [stpc_pkg::HUM_PCT_W-1:0] hum_low_pct_reg, hum_high_pct_reg;
    logic signed [RW-1:0]           hum_low_raw_reg, hum_high_raw_reg;
    logic [stpc_pkg::TEMP_X8_W-1:0] temp_low_x8_reg, temp_high_x8_reg;
    logic signed [RW-1:0]           temp_low_raw_reg, temp_high_raw_reg;

    logic             cfg_wr;
    stpc_pkg::reg_idx_t cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = stpc_pkg::reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_low_pct_reg   <= '0;
            hum_high_pct_reg  <= '0;
            hum_low_raw_reg   <= '0;
            hum_high_raw_reg  <= RW'(1);
            temp_low_x8_reg   <= '0;
            temp_high_x8_reg  <= '0;
            temp_low_raw_reg  <= '0;
            temp_high_raw_reg <= RW'(1);
        end else if (cfg_wr) begin
            case (cfg_idx)
                stpc_pkg::REG_HUM_LOW_PCT:   hum_low_pct_reg   <= pwdata[stpc_pkg::HUM_PCT_W-1:0];
                stpc_pkg::REG_HUM_HIGH_PCT:  hum_high_pct_reg  <= pwdata[stpc_pkg::HUM_PCT_W-1:0];
                stpc_pkg::REG_HUM_LOW_RAW:   hum_low_raw_reg   <= pwdata[RW-1:0];
                stpc_pkg::REG_HUM_HIGH_RAW:  hum_high_raw_reg  <= pwdata[RW-1:0];
                stpc_pkg::REG_TEMP_LOW_X8:   temp_low_x8_reg   <= pwdata[stpc_pkg::TEMP_X8_W-1:0];
                stpc_pkg::REG_TEMP_HIGH_X8:  temp_high_x8_reg  <= pwdata[stpc_pkg::TEMP_X8_W-1:0];
                stpc_pkg::REG_TEMP_LOW_RAW:  temp_low_raw_reg  <= pwdata[RW-1:0];
                stpc_pkg::REG_TEMP_HIGH_RAW: temp_high_raw_reg <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            stpc_pkg::REG_HUM_LOW_PCT:   prdata = 32'(hum_low_pct_reg);
            stpc_pkg::REG_HUM_HIGH_PCT:  prdata = 32'(hum_high_pct_reg);
            stpc_pkg::REG_HUM_LOW_RAW:   prdata = 32'(unsigned'(hum_low_raw_reg));
            stpc_pkg::REG_HUM_HIGH_RAW:  prdata = 32'(unsigned'(hum_high_raw_reg));
            stpc_pkg::REG_TEMP_LOW_X8:   prdata = 32'(temp_low_x8_reg);
            stpc_pkg::REG_TEMP_HIGH_X8:  prdata = 32'(temp_high_x8_reg);
            stpc_pkg::REG_TEMP_LOW_RAW:  prdata = 32'(unsigned'(temp_low_raw_reg));
            stpc_pkg::REG_TEMP_HIGH_RAW: prdata = 32'(unsigned'(temp_high_raw_reg));
            default:                     prdata = '0;
        endcase
    end

    // sequencer and datapath registers
    state_t                state_reg, state_next;
    logic                  op_reg;
    logic signed [RW-1:0]  x_reg;
    logic                  rdy_reg;
    logic [YW-1:0]         y0s_reg, y0s_next;
    logic signed [DYW-1:0] dy_reg, dy_next;
    logic signed [DXW-1:0] dx_reg, dx_next;
    logic [RW-1:0]         den_mag_reg, den_mag_next;
    logic                  den_neg_reg, den_neg_next;
    logic signed [NUMW-1:0] num_reg, num_next;
    logic                  q_neg_reg, q_neg_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic signed [VW-1:0]  last_temp_reg, last_temp_next;
    logic signed [VW-1:0]  res_value_reg, res_value_next;
    logic                  res_stale_reg, res_stale_next;
    logic                  res_derr_reg, res_derr_next;
    logic                  m_valid_reg, m_valid_next;
    logic signed [VW-1:0]  m_value_reg;
    logic                  m_stale_reg, m_div_error_reg;

    // divider hookup
    logic                     div_start;
    logic [NW-1:0]            div_dividend;
    stpc_pkg::stpc_div_stat_t div_stat;
    logic [NW-1:0]            div_quo;

    // calibration operand selection
    logic [YW-1:0]          y0s_c, y1s_c;
    logic signed [RW-1:0]   x0_c, x1_c;
    logic signed [DXW-1:0]  den_c;
    logic signed [NUMW-1:0] num_abs;
    logic signed [NW:0]     q_signed;
    logic signed [EXTW-1:0] sum_ext;
    logic                   out_load;

    always_comb begin
        if (op_reg == stpc_pkg::OP_HUM) begin
            y0s_c = YW'(hum_low_pct_reg) << FRAC_BITS;
            y1s_c = YW'(hum_high_pct_reg) << FRAC_BITS;
            x0_c  = hum_low_raw_reg;
            x1_c  = hum_high_raw_reg;
        end else begin
            y0s_c = YW'(temp_low_x8_reg) << (FRAC_BITS - 3);
            y1s_c = YW'(temp_high_x8_reg) << (FRAC_BITS - 3);
            x0_c  = temp_low_raw_reg;
            x1_c  = temp_high_raw_reg;
        end
        den_c   = DXW'(x1_c) - DXW'(x0_c);
        num_abs = num_reg[NUMW-1] ? -num_reg : num_reg;
        q_signed = q_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        sum_ext  = EXTW'(sum_reg);
    end

    assign div_dividend = num_abs[NW-1:0];
    assign out_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        y0s_next       = y0s_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        den_mag_next   = den_mag_reg;
        den_neg_next   = den_neg_reg;
        num_next       = num_reg;
        q_neg_next     = q_neg_reg;
        sum_next       = sum_reg;
        last_temp_next = last_temp_reg;
        res_value_next = res_value_reg;
        res_stale_next = res_stale_reg;
        res_derr_next  = res_derr_reg;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            // pick operands, catch stale and degenerate cases
            ST_PREP: begin
                y0s_next     = y0s_c;
                dy_next      = $signed({1'b0, y1s_c}) - $signed({1'b0, y0s_c});
                dx_next      = DXW'(x_reg) - DXW'(x0_c);
                den_neg_next = den_c[DXW-1];
                den_mag_next = den_c[DXW-1] ? RW'(-den_c) : RW'(den_c);
                res_stale_next = 1'b0;
                res_derr_next  = 1'b0;
                if (op_reg == stpc_pkg::OP_TEMP && !rdy_reg) begin
                    res_value_next = last_temp_reg;
                    res_stale_next = 1'b1;
                    state_next     = ST_OUT;
                end else if (x1_c == x0_c) begin
                    res_value_next = '0;
                    res_derr_next  = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            // scaled span times raw offset
            ST_MUL: begin
                num_next   = NUMW'(dy_reg) * NUMW'(dx_reg);
                state_next = ST_DLOAD;
            end
            // hand magnitudes to the divider
            ST_DLOAD: begin
                div_start  = 1'b1;
                q_neg_next = num_reg[NUMW-1] ^ den_neg_reg;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    sum_next   = SUMW'($signed({1'b0, y0s_reg})) + SUMW'(q_signed);
                    state_next = ST_SUM;
                end
            end
            // saturate and keep the temperature
            ST_SUM: begin
                if (sum_ext > EXTW'(stpc_pkg::VAL_MAX)) begin
                    res_value_next = stpc_pkg::VAL_MAX;
                end else if (sum_ext < EXTW'(stpc_pkg::VAL_MIN)) begin
                    res_value_next = stpc_pkg::VAL_MIN;
                end else begin
                    res_value_next = sum_ext[VW-1:0];
                end
                if (op_reg == stpc_pkg::OP_TEMP) begin
                    last_temp_next = res_value_next;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result buffer handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_temp_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_temp_reg <= last_temp_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_opcode;
            x_reg   <= s_raw_sample;
            rdy_reg <= s_sample_ready;
        end
        y0s_reg       <= y0s_next;
        dy_reg        <= dy_next;
        dx_reg        <= dx_next;
        den_mag_reg   <= den_mag_next;
        den_neg_reg   <= den_neg_next;
        num_reg       <= num_next;
        q_neg_reg     <= q_neg_next;
        sum_reg       <= sum_next;
        res_value_reg <= res_value_next;
        res_stale_reg <= res_stale_next;
        res_derr_reg  <= res_derr_next;
        if (out_load) begin
            m_value_reg     <= res_value_reg;
            m_stale_reg     <= res_stale_reg;
            m_div_error_reg <= res_derr_reg;
        end
    end

    stpc_div #(
        .NW(NW),
        .DW(RW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (den_mag_reg),
        .status  (div_stat),
        .quotient(div_quo)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_stale     = m_stale_reg;
    assign m_div_error = m_div_error_reg;

`ifndef NO_ASSERTIONS
    // an accepted request goes straight to operand setup
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_PREP))
        else $error("request not taken into setup");

    // divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");

    // stale and division error never together
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stale && m_div_error))
        else $error("stale and error both set");

    // humidity results are never stale
    a_hum_not_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && op_reg == stpc_pkg::OP_HUM) |-> !res_stale_reg)
        else $error("stale humidity result");
`endif

endmodule

// File: src/stpc_div.sv
// restoring unsigned divider, one quotient bit per cycle
module stpc_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [NW-1:0]           dividend,
    input  logic [DW-1:0]           divisor,
    output stpc_pkg::stpc_div_stat_t status,
    output logic [NW-1:0]           quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          fits;

    // trial subtraction of the shifted remainder
    always_comb begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        fits  = ~diff[DW+1];
    end

    // step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

`ifndef NO_ASSERTIONS
    // a start puts the divider to work
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider not busy after start");

    // completion ends the run
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider busy while done");

    // partial remainder stays below the divisor while running
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && $past(busy_reg)) |-> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");
`endif

endmodule
